### sv/hcv_pkg.sv
// Package for the HSV color vote classifier: types, constants, register codes.
// No dependencies.
`default_nettype none
package hcv_pkg;
    localparam int unsigned TallyWidth = 17;
    localparam int unsigned RegWidth   = 24;
    localparam int unsigned NumRegs    = 6;
    localparam int unsigned DefMaxBoxPixels = 65536;

    typedef enum logic [2:0] {
        REG_RED_LO = 3'd0, REG_RED_HI = 3'd1, REG_YEL_LO = 3'd2,
        REG_YEL_HI = 3'd3, REG_GRN_LO = 3'd4, REG_GRN_HI = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        COLOR_NONE = 2'd0, COLOR_RED = 2'd1, COLOR_YELLOW = 2'd2, COLOR_GREEN = 2'd3
    } color_t;

    localparam logic [RegWidth-1:0] RED_LO_RST = 24'h0045F6;
    localparam logic [RegWidth-1:0] RED_HI_RST = 24'h0BE0FF;
    localparam logic [RegWidth-1:0] YEL_LO_RST = 24'h1E90A8;
    localparam logic [RegWidth-1:0] YEL_HI_RST = 24'h25E8FF;
    localparam logic [RegWidth-1:0] GRN_LO_RST = 24'h337AF0;
    localparam logic [RegWidth-1:0] GRN_HI_RST = 24'h43EEFF;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MINMAX, ST_DIV_S, ST_DIV_H, ST_MATCH, ST_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic div_start_s;
        logic div_start_h;
        logic do_match;
        logic emit;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
        logic last;
    } sts_t;
endpackage
`default_nettype wire

### sv/hcv_div.sv
// Restoring divider, one quotient bit per cycle; done pulses once the quotient is final.
// Depends on nothing.
`default_nettype none
module hcv_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [16:0] num,
    input  wire logic [9:0]  den,
    output logic [16:0]      quo,
    output logic             done
);
    logic [16:0] q_reg, q_next;
    logic [9:0]  r_reg, r_next;
    logic [9:0]  den_reg, den_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [10:0] trial;

    always_comb
    begin
        q_next = q_reg; r_next = r_reg; den_next = den_reg;
        cnt_next = cnt_reg; busy_next = busy_reg;
        done_next = 1'b0;
        trial = {r_reg, q_reg[16]};
        if (start)
        begin
            q_next = num; r_next = '0; den_next = den;
            cnt_next = 5'd17; busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // remainder stays below den, so 10 bits hold it
            if (trial >= {1'b0, den_reg})
            begin
                r_next = 10'(trial - {1'b0, den_reg});
                q_next = {q_reg[15:0], 1'b1};
            end
            else
            begin
                r_next = trial[9:0];
                q_next = {q_reg[15:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        den_reg <= den_next;
    end

    assign quo  = q_reg;
    assign done = done_reg;
endmodule
`default_nettype wire

### sv/hcv_datapath.sv
// Datapath: pixel capture, HSV conversion, window test, tallies, result register.
// Depends on hcv_pkg and hcv_div.
`default_nettype none
module hcv_datapath #(
    parameter int unsigned MAX_BOX_PIXELS = hcv_pkg::DefMaxBoxPixels
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire hcv_pkg::cmd_t          cmd,
    output hcv_pkg::sts_t               sts,
    input  wire logic [39:0]            in_data,
    input  wire logic                   in_last,
    input  wire logic                   cfg_we,
    input  wire logic [2:0]             cfg_idx,
    input  wire logic [23:0]            cfg_data,
    output logic [15:0]                 out_box_id,
    output logic [1:0]                  out_color,
    output logic [16:0]                 out_red,
    output logic [16:0]                 out_yellow,
    output logic [16:0]                 out_green
);
    import hcv_pkg::*;

    localparam int unsigned CapRaw = (MAX_BOX_PIXELS > 131071) ? 131071 : MAX_BOX_PIXELS;
    localparam logic [TallyWidth-1:0] Cap = TallyWidth'(CapRaw);

    logic [23:0] cfg_reg [NumRegs];
    logic [7:0]  r_reg, g_reg, b_reg, v_reg, d_reg, s_reg;
    logic [15:0] id_reg;
    logic        last_reg;
    logic [10:0] n_reg;
    logic [16:0] red_reg, yel_reg, grn_reg;
    logic [16:0] red_next, yel_next, grn_next;

    logic [7:0]  mx, mn, dm;
    logic [10:0] n_calc;
    logic [16:0] div_num;
    logic [9:0]  div_den;
    logic [16:0] quo;
    logic        div_done;
    logic [7:0]  hue;
    logic        m_red, m_yel, m_grn;
    logic [1:0]  color;

    function automatic logic in_win(input logic [7:0] h, input logic [7:0] s,
                                    input logic [7:0] v, input logic [23:0] lo,
                                    input logic [23:0] hi);
        in_win = h >= lo[23:16] && h <= hi[23:16] && s >= lo[15:8] && s <= hi[15:8]
              && v >= lo[7:0] && v <= hi[7:0];
    endfunction

    always_comb
    begin
        mx = r_reg;
        if (g_reg > mx) mx = g_reg;
        if (b_reg > mx) mx = b_reg;
        mn = r_reg;
        if (g_reg < mn) mn = g_reg;
        if (b_reg < mn) mn = b_reg;
    end

    assign dm = mx - mn;

    // hue numerator index n in 0..6d, kept as 11 bits
    always_comb
    begin
        if (v_reg == r_reg)
            n_calc = (g_reg >= b_reg) ? {3'b0, g_reg - b_reg}
                   : 11'({3'b0, g_reg} + 11'd6 * {3'b0, d_reg} - {3'b0, b_reg});
        else if (v_reg == g_reg)
            n_calc = 11'({3'b0, b_reg} + 11'd2 * {3'b0, d_reg} - {3'b0, r_reg});
        else
            n_calc = 11'({3'b0, r_reg} + 11'd4 * {3'b0, d_reg} - {3'b0, g_reg});
    end

    // saturation operands come straight from min/max; v_reg and d_reg load on the same edge
    always_comb
    begin
        if (cmd.div_start_s)
        begin
            div_num = 17'd510 * {9'b0, dm} + {9'b0, mx};
            div_den = {1'b0, mx, 1'b0};
        end
        else
        begin
            div_num = 17'd60 * {6'b0, n_reg} + {9'b0, d_reg};
            div_den = {1'b0, d_reg, 1'b0};
        end
    end

    hcv_div u_div (
        .clk(clk), .rst_n(rst_n),
        .start(cmd.div_start_s | cmd.div_start_h),
        .num(div_num), .den(div_den), .quo(quo), .done(div_done)
    );

    assign hue = (d_reg == 8'd0) ? 8'd0
               : (quo[7:0] >= 8'd180 ? quo[7:0] - 8'd180 : quo[7:0]);

    assign m_red = in_win(hue, s_reg, v_reg, cfg_reg[REG_RED_LO], cfg_reg[REG_RED_HI]);
    assign m_yel = in_win(hue, s_reg, v_reg, cfg_reg[REG_YEL_LO], cfg_reg[REG_YEL_HI]);
    assign m_grn = in_win(hue, s_reg, v_reg, cfg_reg[REG_GRN_LO], cfg_reg[REG_GRN_HI]);

    always_comb
    begin
        red_next = red_reg; yel_next = yel_reg; grn_next = grn_reg;
        if (cmd.do_match)
        begin
            if (m_red && red_reg < Cap) red_next = red_reg + 17'd1;
            if (m_yel && yel_reg < Cap) yel_next = yel_reg + 17'd1;
            if (m_grn && grn_reg < Cap) grn_next = grn_reg + 17'd1;
        end
        if (cmd.emit)
        begin
            red_next = '0; yel_next = '0; grn_next = '0;
        end
    end

    always_comb
    begin
        if (red_reg > yel_reg && red_reg > grn_reg)      color = COLOR_RED;
        else if (yel_reg > red_reg && yel_reg > grn_reg) color = COLOR_YELLOW;
        else if (grn_reg > red_reg && grn_reg > yel_reg) color = COLOR_GREEN;
        else                                             color = COLOR_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[REG_RED_LO] <= RED_LO_RST;
            cfg_reg[REG_RED_HI] <= RED_HI_RST;
            cfg_reg[REG_YEL_LO] <= YEL_LO_RST;
            cfg_reg[REG_YEL_HI] <= YEL_HI_RST;
            cfg_reg[REG_GRN_LO] <= GRN_LO_RST;
            cfg_reg[REG_GRN_HI] <= GRN_HI_RST;
            red_reg <= '0; yel_reg <= '0; grn_reg <= '0;
        end
        else
        begin
            if (cfg_we && cfg_idx <= REG_GRN_HI) cfg_reg[cfg_idx] <= cfg_data;
            red_reg <= red_next; yel_reg <= yel_next; grn_reg <= grn_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            b_reg <= in_data[7:0]; g_reg <= in_data[15:8]; r_reg <= in_data[23:16];
            id_reg <= in_data[39:24]; last_reg <= in_last;
        end
        if (cmd.div_start_s)
        begin
            v_reg <= mx; d_reg <= dm;
        end
        // first cycle after minmax: S division runs, capture n
        n_reg <= n_calc;
        if (div_done && !cmd.div_start_h && !cmd.do_match)
            s_reg <= (v_reg == 8'd0) ? 8'd0 : quo[7:0];
        if (cmd.emit)
        begin
            out_box_id <= id_reg; out_color <= color;
            out_red <= red_reg; out_yellow <= yel_reg; out_green <= grn_reg;
        end
    end

    assign sts.div_done = div_done;
    assign sts.last     = last_reg;
endmodule
`default_nettype wire

### sv/hcv_ctrl.sv
// Controller state machine sequencing one pixel through the datapath.
// Depends on hcv_pkg.
`default_nettype none
module hcv_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    output hcv_pkg::cmd_t      cmd,
    input  wire hcv_pkg::sts_t sts
);
    import hcv_pkg::*;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;

    always_comb
    begin
        state_next = state_reg;
        ov_next = ov_reg;
        cmd = '0;
        in_ready = 1'b0;
        if (ov_reg && out_ready) ov_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_MINMAX;
                end
            end
            ST_MINMAX:
            begin
                cmd.div_start_s = 1'b1;
                state_next = ST_DIV_S;
            end
            ST_DIV_S:
                if (sts.div_done) state_next = ST_DIV_H;
            ST_DIV_H:
            begin
                cmd.div_start_h = 1'b1;
                state_next = ST_MATCH;
            end
            ST_MATCH:
                if (sts.div_done)
                begin
                    cmd.do_match = 1'b1;
                    state_next = sts.last ? ST_OUT : ST_IDLE;
                end
            ST_OUT:
                if (!ov_reg || out_ready)
                begin
                    cmd.emit = 1'b1;
                    ov_next = 1'b1;
                    state_next = ST_IDLE;
                end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
        end
    end

    assign out_valid = ov_reg;

    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!ov_reg || out_ready)) else $error("result overwritten");
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == ST_IDLE) else $error("ready outside idle");
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid) else $error("emit lost");
endmodule
`default_nettype wire

### sv/hsv_color_vote_classifier.sv
// Top level of the HSV color vote classifier.
// Depends on hcv_pkg, hcv_ctrl, hcv_datapath, hcv_div.
// Each pixel passes through these steps: an accept cycle, a min/max cycle that starts the
// saturation division, a wait until that 17-step division on the shared
// bit-serial divider reports done, a cycle to start the hue division and a wait
// until it is done, the window test and tally update falling in the cycle it reports done.
// A box's last pixel then passes through an output state that loads the result register,
// and waits there while an earlier result is still unaccepted.
// The result register lets the next pixel be taken while a result waits.
`default_nettype none
module hsv_color_vote_classifier #(
    parameter int unsigned MAX_BOX_PIXELS = hcv_pkg::DefMaxBoxPixels
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // pixel_blue, pixel_green, pixel_red, box_id
    input  wire logic        s_axis_tlast,  // last_pixel
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,  // result_box_id, light_color, red, yellow, green
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);
    import hcv_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic [15:0] box_id;
    logic [1:0]  color;
    logic [16:0] rc, yc, gc;

    hcv_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .cmd(cmd), .sts(sts)
    );

    hcv_datapath #(.MAX_BOX_PIXELS(MAX_BOX_PIXELS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .in_data(s_axis_tdata), .in_last(s_axis_tlast),
        .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
        .out_box_id(box_id), .out_color(color),
        .out_red(rc), .out_yellow(yc), .out_green(gc)
    );

    assign m_axis_tdata = {3'b0, gc, yc, rc, color, box_id};
endmodule
`default_nettype wire
